/* hdl/osia_pkg.sv */
// shared types and defaults for the operand stack with indexed access
// no dependencies; used by every module of the block
`default_nettype none

package osia_pkg;

  localparam int DEPTH_DEF       = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    REQ_PUSH      = 3'd0,
    REQ_POP       = 3'd1,
    REQ_POP_N     = 3'd2,
    REQ_GROW_N    = 3'd3,
    REQ_READ_IDX  = 3'd4,
    REQ_WRITE_IDX = 3'd5,
    REQ_READ_TOP  = 3'd6,
    REQ_WRITE_TOP = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  // store port controls for one request
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // per-request result info carried alongside the read data
  typedef struct packed {
    logic    rd;
    status_t status;
  } res_info_t;

endpackage

`default_nettype wire

/* hdl/operand_stack_with_indexed_access_top.sv */
// top level of the operand stack with indexed access
// depends on osia_pkg, osia_ctrl, osia_ram and osia_out_stage
// a result is registered in the result stage at its input transfer and moves to the
//   output register, where it is offered, once that register is free or being taken
// throughput: one request per cycle while the result channel is ready; the store has one
//   port, each request makes at most one read or one write, and depth updates on the transfer
// the result stage and output register let one more request in while a result waits
// reset clears the depth and empties the pipeline; store contents are not cleared
`default_nettype none

module operand_stack_with_indexed_access_top #(
  parameter int DEPTH       = osia_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = osia_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = $clog2(DEPTH + 1),
  parameter int IN_TD_W     = ((CNT_W + VALUE_WIDTH + 7) / 8) * 8,
  parameter int OUT_TD_W    = ((VALUE_WIDTH + CNT_W + 1 + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // request channel
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // tdata from lsb: index_or_count, value_in, zero fill
  input  wire logic [IN_TD_W-1:0]  s_tdata,
  // tuser: req_type
  input  wire logic [2:0]          s_tuser,
  // result channel
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // tdata from lsb: read_value, depth_after, is_empty, zero fill
  output logic      [OUT_TD_W-1:0] m_tdata,
  // tuser: status
  output logic      [1:0]          m_tuser
);

  localparam int ADDR_W = $clog2(DEPTH);

  // request transfer
  logic acc;
  assign acc = s_tvalid && s_tready;

  // unpack request fields
  osia_pkg::req_t          req;
  logic [CNT_W-1:0]        n;
  logic [VALUE_WIDTH-1:0]  value_in;

  assign req      = osia_pkg::req_t'(s_tuser);
  assign n        = s_tdata[CNT_W-1:0];
  assign value_in = s_tdata[CNT_W +: VALUE_WIDTH];

  osia_pkg::mem_ctl_t      ctl;
  logic [ADDR_W-1:0]       addr;
  logic [CNT_W-1:0]        depth;
  logic [CNT_W-1:0]        depth_next;
  osia_pkg::res_info_t     info;
  logic [VALUE_WIDTH-1:0]  rdata;

  // decode, bounds checks and depth counter
  osia_ctrl #(
    .DEPTH  (DEPTH),
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .req        (req),
    .n          (n),
    .ctl        (ctl),
    .addr       (addr),
    .depth      (depth),
    .depth_next (depth_next),
    .info       (info)
  );

  // stack store, read data lands with the result stage
  osia_ram #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (addr),
    .wdata (value_in),
    .rdata (rdata)
  );

  logic [VALUE_WIDTH-1:0]  out_value;
  logic [CNT_W-1:0]        out_depth;
  logic                    out_empty;
  osia_pkg::status_t       out_status;

  // result stage plus output register
  osia_out_stage #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .depth_next (depth_next),
    .info       (info),
    .rdata      (rdata),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (out_value),
    .out_depth  (out_depth),
    .out_empty  (out_empty),
    .out_status (out_status)
  );

  // pack result fields, zero fill on top
  assign m_tdata = OUT_TD_W'({out_empty, out_depth, out_value});
  assign m_tuser = out_status;

`ifndef SYNTH
  // a flagged request leaves the depth alone
  a_flag_keeps_depth: assert property (@(posedge clk) disable iff (rst)
    (acc && info.status != osia_pkg::ST_OK) |=> $stable(depth))
    else $error("flagged request changed the depth");

  // depth moves only on a request transfer
  a_depth_idle: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(depth))
    else $error("depth changed without a request transfer");

  // a request never both reads and writes the store
  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    ctl.we |-> !ctl.re)
    else $error("store read and write in the same request");

  // store is only touched by an accepted request
  a_mem_on_acc: assert property (@(posedge clk) disable iff (rst)
    (ctl.we || ctl.re) |-> acc)
    else $error("store access without a request transfer");
`endif

endmodule

`default_nettype wire

/* hdl/osia_ctrl.sv */
// request decode, bounds checks and depth register
// depends on osia_pkg
`default_nettype none

module osia_ctrl #(
  parameter int DEPTH  = osia_pkg::DEPTH_DEF,
  parameter int CNT_W  = $clog2(DEPTH + 1),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               acc,
  input  wire osia_pkg::req_t     req,
  input  wire logic [CNT_W-1:0]   n,
  output osia_pkg::mem_ctl_t      ctl,
  output logic      [ADDR_W-1:0]  addr,
  output logic      [CNT_W-1:0]   depth,
  output logic      [CNT_W-1:0]   depth_next,
  output osia_pkg::res_info_t     info
);

  localparam logic [CNT_W-1:0] CAP   = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   CAP_X = (CNT_W + 1)'(DEPTH);

  logic             full;
  logic             in_range;
  logic [CNT_W:0]   grow_sum;
  logic [CNT_W-1:0] below_top;
  logic [CNT_W-1:0] top_dist;
  osia_pkg::mem_ctl_t ctl_c;

  always_comb begin
    full      = (depth == CAP);
    in_range  = (n < depth);
    grow_sum  = {1'b0, depth} + {1'b0, n};
    below_top = depth - CNT_W'(1);
    top_dist  = depth - n - CNT_W'(1);

    ctl_c       = '0;
    addr        = depth[ADDR_W-1:0];
    depth_next  = depth;
    info.rd     = 1'b0;
    info.status = osia_pkg::ST_OK;

    unique case (req)
      osia_pkg::REQ_PUSH: begin
        if (full) begin
          info.status = osia_pkg::ST_OVER;
        end else begin
          ctl_c.we   = 1'b1;
          depth_next = depth + CNT_W'(1);
        end
      end
      osia_pkg::REQ_POP: begin
        if (depth == '0) begin
          info.status = osia_pkg::ST_UNDER;
        end else begin
          ctl_c.re   = 1'b1;
          info.rd    = 1'b1;
          addr       = below_top[ADDR_W-1:0];
          depth_next = below_top;
        end
      end
      osia_pkg::REQ_POP_N: begin
        if (n > depth) begin
          info.status = osia_pkg::ST_UNDER;
        end else begin
          depth_next = depth - n;
        end
      end
      osia_pkg::REQ_GROW_N: begin
        if (grow_sum > CAP_X) begin
          info.status = osia_pkg::ST_OVER;
        end else begin
          depth_next = grow_sum[CNT_W-1:0];
        end
      end
      osia_pkg::REQ_READ_IDX, osia_pkg::REQ_WRITE_IDX: begin
        addr = n[ADDR_W-1:0];
        if (!in_range) begin
          info.status = osia_pkg::ST_UNDER;
        end else if (req == osia_pkg::REQ_READ_IDX) begin
          ctl_c.re = 1'b1;
          info.rd  = 1'b1;
        end else begin
          ctl_c.we = 1'b1;
        end
      end
      osia_pkg::REQ_READ_TOP, osia_pkg::REQ_WRITE_TOP: begin
        addr = top_dist[ADDR_W-1:0];
        if (!in_range) begin
          info.status = osia_pkg::ST_UNDER;
        end else if (req == osia_pkg::REQ_READ_TOP) begin
          ctl_c.re = 1'b1;
          info.rd  = 1'b1;
        end else begin
          ctl_c.we = 1'b1;
        end
      end
      default: begin
        info.status = osia_pkg::ST_UNDER;
      end
    endcase

    ctl.we = acc & ctl_c.we;
    ctl.re = acc & ctl_c.re;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (acc) begin
      depth <= depth_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/osia_ram.sv */
// single-port stack store with registered read
// depends on osia_pkg for the control struct
`default_nettype none

module osia_ram #(
  parameter int DEPTH       = osia_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = osia_pkg::VALUE_WIDTH_DEF,
  parameter int ADDR_W      = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire osia_pkg::mem_ctl_t       ctl,
  input  wire logic [ADDR_W-1:0]        addr,
  input  wire logic [VALUE_WIDTH-1:0]   wdata,
  output logic      [VALUE_WIDTH-1:0]   rdata
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    // read data holds while no read is issued
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/osia_out_stage.sv */
// result stage and output register with stream handshake
// depends on osia_pkg
`default_nettype none

module osia_out_stage #(
  parameter int VALUE_WIDTH = osia_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = $clog2(osia_pkg::DEPTH_DEF + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     acc,
  input  wire logic [CNT_W-1:0]         depth_next,
  input  wire osia_pkg::res_info_t      info,
  input  wire logic [VALUE_WIDTH-1:0]   rdata,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [VALUE_WIDTH-1:0]   out_value,
  output logic      [CNT_W-1:0]         out_depth,
  output logic                          out_empty,
  output osia_pkg::status_t             out_status
);

  logic                res_valid;
  logic [CNT_W-1:0]    res_depth;
  osia_pkg::res_info_t res_info;
  logic                res_move;

  assign res_move = res_valid && (!out_valid || out_ready);
  assign in_ready = !res_valid || res_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_depth <= depth_next;
      res_info  <= info;
    end
    if (res_move) begin
      out_value  <= res_info.rd ? rdata : '0;
      out_depth  <= res_depth;
      out_empty  <= (res_depth == '0);
      out_status <= res_info.status;
    end
  end

endmodule

`default_nettype wire
